@@ sv/tpq_pkg.sv @@
`timescale 1ns / 1ps

package tpq_pkg;

   localparam logic signed [31:0] URGENT_RESET = 32'sd5;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_SCAN,
      S_SHIFT,
      S_DSHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_value;
      logic [4:0]         out_count;
   } rsp_type;

endpackage

@@ sv/tpq_store.sv @@
`timescale 1ns / 1ps

module tpq_store #(
   parameter int QUEUE_DEPTH = 16,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [31:0]       wr_data,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [31:0]       rd_data
);

   logic signed [31:0] mem [QUEUE_DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/threshold_priority_queue.sv @@
`timescale 1ns / 1ps

// Bounded ordered queue of signed 32-bit values held in one single-port-write,
// registered-read memory with the head at address 0. An item either enqueues
// or dequeues and gives exactly one result item. Insert into an empty queue,
// append at the tail and any status-only result need no pass over the entries;
// an insert at the head, a sorted insert or a dequeue streams once
// through the held entries (read one address, write back one address per
// cycle). One item is in flight at a time; the result sits in an output
// register, so a waiting result does not block the next item from starting.
// The urgent limit resets to 5 and should only be written while the queue
// is idle.
module threshold_priority_queue
   import tpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic signed [31:0] csr_wr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic signed [31:0] carry_ff, carry_in;
   logic               op_ff, op_in;
   logic signed [31:0] value_ff, value_in;
   status_type         pend_status_ff, pend_status_in;
   logic signed [31:0] pend_value_ff, pend_value_in;
   logic signed [31:0] limit_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               rsp_load;

   logic               wr_en;
   logic [CNT_W-1:0]   wr_cnt;
   logic signed [31:0] wr_data;
   logic [CNT_W-1:0]   rd_cnt;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] rd_data;

   // reads always run ahead of writes in a pass, so no entry is read and written together
   assign rd_addr = (rd_cnt < DEPTH_C) ? rd_cnt[IDX_W-1:0] : '0;
   assign wr_addr = wr_cnt[IDX_W-1:0];

   tpq_store #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         limit_ff <= URGENT_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      carry_ff       <= carry_in;
      op_ff          <= op_in;
      value_ff       <= value_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.status    <= pend_status_ff;
         rsp_data_ff.out_value <= pend_value_ff;
         rsp_data_ff.out_count <= 5'(count_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      carry_in       = carry_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      wr_en          = 1'b0;
      wr_cnt         = '0;
      wr_data        = value_ff;
      rd_cnt         = '0;
      rsp_load       = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_data.op;
               value_in = req_data.value;
               state_in = S_HEAD;
            end
         end

         S_HEAD: begin
            // head entry is on rd_data now; entry 1 is fetched for the pass
            rd_cnt         = CNT_W'(1);
            idx_in         = CNT_W'(1);
            pend_status_in = ST_DONE;
            pend_value_in  = '0;
            if (op_ff == OP_ENQ) begin
               if (count_ff == DEPTH_C) begin
                  pend_status_in = ST_FULL;
                  state_in       = S_RESP;
               end else if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  state_in = S_RESP;
               end else if (value_ff < rd_data) begin
                  wr_en    = 1'b1;
                  carry_in = rd_data;
                  state_in = S_SHIFT;
               end else if (value_ff <= limit_ff) begin
                  state_in = S_SCAN;
               end else begin
                  wr_en    = 1'b1;
                  wr_cnt   = count_ff;
                  count_in = count_ff + 1'b1;
                  state_in = S_RESP;
               end
            end else begin
               if (count_ff == '0) begin
                  pend_status_in = ST_EMPTY;
                  state_in       = S_RESP;
               end else begin
                  pend_value_in = rd_data;
                  state_in      = S_DSHIFT;
               end
            end
         end

         S_SCAN: begin
            rd_cnt = idx_ff + 1'b1;
            wr_cnt = idx_ff;
            if (idx_ff == count_ff) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_RESP;
            end else if (rd_data < value_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               wr_en    = 1'b1;
               carry_in = rd_data;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            // ripple the displaced entry one place toward the tail
            rd_cnt  = idx_ff + 1'b1;
            wr_cnt  = idx_ff;
            wr_data = carry_ff;
            wr_en   = 1'b1;
            if (idx_ff == count_ff) begin
               count_in = count_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               carry_in = rd_data;
               idx_in   = idx_ff + 1'b1;
            end
         end

         S_DSHIFT: begin
            rd_cnt  = idx_ff + 1'b1;
            wr_cnt  = idx_ff - 1'b1;
            wr_data = rd_data;
            if (idx_ff == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end else begin
               wr_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/tpq_checker.sv @@
`timescale 1ns / 1ps

module tpq_checker
   import tpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rsp_type            rsp_data
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // only a successful dequeue carries a value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.out_value == 32'sd0)
      else $error("nonzero value on a failed operation");

   // a dropped item means the queue is full, an empty dequeue means it is empty
   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_EMPTY) |->
         (rsp_data.status == ST_FULL && rsp_data.out_count == 5'(QUEUE_DEPTH)) ||
         (rsp_data.status == ST_EMPTY && rsp_data.out_count == 5'd0))
      else $error("status disagrees with count");

endmodule

bind threshold_priority_queue tpq_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_tpq_checker (.*);

@@ test/tpq_score_pkg.sv @@
`timescale 1ns / 1ps

package tpq_score_pkg;
   import tpq_pkg::*;

   localparam int HELD_MAX = 16;

   class tpq_scoreboard;
      logic signed [31:0] shadow_entries [HELD_MAX];
      int                 shadow_count;
      logic signed [31:0] shadow_limit;
      rsp_type            awaited_rsp [$];
      int                 failures;

      function new();
         shadow_count = 0;
         shadow_limit = URGENT_RESET;
         failures     = 0;
      endfunction

      function void set_limit(logic signed [31:0] v);
         shadow_limit = v;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      function logic signed [31:0] head_value();
         return (shadow_count > 0) ? shadow_entries[0] : 32'sd0;
      endfunction

      // apply one accepted item to the shadow queue and queue its result
      function void note_request(req_type r);
         rsp_type            e;
         logic signed [31:0] v;
         int                 pos;
         v           = r.value;
         e.status    = ST_DONE;
         e.out_value = '0;
         if (r.op == OP_ENQ) begin
            if (shadow_count >= HELD_MAX) begin
               e.status = ST_FULL;
            end else begin
               if (shadow_count == 0 || v < shadow_entries[0]) begin
                  pos = 0;
               end else if (v <= shadow_limit) begin
                  pos = 1;
                  while (pos < shadow_count && shadow_entries[pos] < v)
                     pos++;
               end else begin
                  pos = shadow_count;
               end
               for (int i = shadow_count; i > pos; i--)
                  shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[pos] = v;
               shadow_count++;
            end
         end else begin
            if (shadow_count == 0) begin
               e.status = ST_EMPTY;
            end else begin
               e.out_value = shadow_entries[0];
               for (int i = 1; i < shadow_count; i++)
                  shadow_entries[i - 1] = shadow_entries[i];
               shadow_count--;
            end
         end
         e.out_count = 5'(shadow_count);
         awaited_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: result item with none awaited: status %0d value %0d count %0d",
                     $time, got.status, got.out_value, got.out_count);
            failures++;
            return;
         end
         e = awaited_rsp.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
            failures++;
         end
         if (got.out_value !== e.out_value) begin
            $display("%0t: out_value expected %0d got %0d", $time, e.out_value,
                     got.out_value);
            failures++;
         end
         if (got.out_count !== e.out_count) begin
            $display("%0t: out_count expected %0d got %0d", $time, e.out_count,
                     got.out_count);
            failures++;
         end
      endfunction
   endclass

endpackage

@@ test/threshold_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module threshold_priority_queue_tb;
   import tpq_pkg::*;
   import tpq_score_pkg::*;

   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 105;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 4000;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_wr_en;
   logic signed [31:0] csr_wr_data;

   logic gaps_on;
   logic stall_on;
   logic long_hold;

   tpq_scoreboard sb = new();

   threshold_priority_queue #(
      .QUEUE_DEPTH(HELD_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input req_type r);
      if (gaps_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 18)) @(negedge clock);
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic enqueue(input logic signed [31:0] v);
      req_type r;
      r.op    = OP_ENQ;
      r.value = v;
      send_item(r);
   endtask

   task automatic dequeue();
      req_type r;
      r.op    = OP_DEQ;
      r.value = $urandom;
      send_item(r);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(input logic signed [31:0] v);
      csr_wr_data = v;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.set_limit(v);
   endtask

   // values cluster around the limit and the head so sorted inserts collide
   function automatic logic signed [31:0] pick_value();
      int d;
      d = $urandom_range(0, 6) - 3;
      case ($urandom_range(0, 9))
         0, 1, 2: return sb.shadow_limit + d;
         3, 4:    return d * 2;
         5:       return sb.head_value() + (d % 2);
         6:       return ($urandom_range(0, 1) != 0) ? INT_MAX : INT_MIN;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_chunk(input int n, input int enq_pct);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r.op    = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
         r.value = pick_value();
         send_item(r);
      end
   endtask

   initial begin
      logic signed [31:0] limit_plan [PHASES];
      int                 sent;
      int                 n;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      gaps_on     = 1'b1;
      stall_on    = 1'b1;
      long_hold   = 1'b0;
      limit_plan  = '{INT_MIN, INT_MAX, 32'sd0, URGENT_RESET, -32'sd1, 32'sd0, 32'sd0};
      limit_plan[5] = $urandom;
      limit_plan[6] = $signed($urandom_range(0, 40)) - 20;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part under the reset limit
      dequeue();
      enqueue(32'sd5);
      enqueue(32'sd3);
      enqueue(32'sd3);
      enqueue(32'sd4);
      enqueue(32'sd5);
      enqueue(32'sd6);
      enqueue(INT_MAX);
      enqueue(INT_MIN);
      enqueue(-32'sd1);
      enqueue(32'sd100);
      enqueue(32'sd2);
      enqueue(32'sd7);
      enqueue(32'sd0);
      enqueue(32'sd1);
      enqueue(-32'sd5);
      enqueue(32'sd6);
      enqueue(32'sd9);
      repeat (4) dequeue();

      for (int p = 0; p < PHASES; p++) begin
         // sender pauses here until all results are back
         wait_drained();
         write_limit(limit_plan[p]);
         stall_on = (p != PHASES - 1);
         sent     = 0;
         if (p == 2) begin
            long_hold = 1'b1;
            gaps_on   = 1'b0;
            run_chunk(30, 70);
            sent = 30;
         end
         while (sent < PHASE_ITEMS) begin
            n       = $urandom_range(8, 24);
            gaps_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
               0:       run_chunk(n, 90);
               1:       run_chunk(n, 15);
               default: run_chunk(n, 55);
            endcase
            sent += n;
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d result items never arrived", $time, sb.pending());
         $display("FAIL");
      end
      $finish;
   end

endmodule
